// ===== sv/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg: shared definitions of the windowed median image filter
// Configuration register indexes, the configuration record and the defaults
// of the top-level parameters.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxRadiusDef = 7;
  localparam int unsigned PixelBitsDef = 16;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned RadiusBits  = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_X_BORDER,
    REG_Y_BORDER,
    REG_X_RADIUS,
    REG_Y_RADIUS,
    REG_SIGNED
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] source_width;
    logic [15:0] source_height;
    logic [9:0]  x_border;
    logic [14:0] y_border;
    logic [2:0]  x_radius;
    logic [2:0]  y_radius;
    logic        signed_pixels;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    source_width:  11'd1024,
    source_height: 16'd1024,
    x_border:      10'd7,
    y_border:      15'd7,
    x_radius:      3'd1,
    y_radius:      3'd1,
    signed_pixels: 1'b0
  };

endpackage

// ===== sv/wmf_if.sv =====
// ----------------------------------------------------------------------------
// wmf_if: channel interfaces of the windowed median image filter
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface wmf_pixel_if #(
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface wmf_result_if #(
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] median;
  logic                  frame_last;
  modport source (output valid, output median, output frame_last, input ready);
  modport sink   (input valid, input median, input frame_last, output ready);
endinterface

interface wmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wmf_pkg::CfgIdxBits-1:0]  index;
  logic [wmf_pkg::CfgDataBits-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wmf_line_store.sv =====
// ----------------------------------------------------------------------------
// wmf_line_store: line buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wmf_line_store #(
  parameter int unsigned DEPTH     = 15 * wmf_pkg::MaxWidthDef,
  parameter int unsigned ADDR_BITS = $clog2(DEPTH),
  parameter int unsigned DATA_BITS = wmf_pkg::PixelBitsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wmf_front.sv =====
// ----------------------------------------------------------------------------
// wmf_front: pixel intake and classification
// Tracks the frame position, writes each pixel into the line store and
// queues a window job for every pixel that completes an interior window.
// ----------------------------------------------------------------------------
module wmf_front #(
  parameter int unsigned MAX_WIDTH  = wmf_pkg::MaxWidthDef,
  parameter int unsigned MAX_RADIUS = wmf_pkg::MaxRadiusDef,
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef,
  localparam int unsigned StoreRows = 2 * MAX_RADIUS + 1,
  localparam int unsigned SlotBits  = $clog2(StoreRows),
  localparam int unsigned ColBits   = $clog2(MAX_WIDTH),
  localparam int unsigned AddrBits  = $clog2(StoreRows * MAX_WIDTH),
  localparam int unsigned RadBits   = wmf_pkg::RadiusBits,
  localparam int unsigned EntryBits = ColBits + SlotBits + 2 * RadBits + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wmf_pkg::cfg_t         cfg_i,
  input  logic                  pix_valid_i,
  input  logic [PIXEL_BITS-1:0] pix_data_i,
  output logic                  pix_ready_o,
  input  logic                  hold_i,
  output logic                  st_we_o,
  output logic [AddrBits-1:0]   st_waddr_o,
  output logic [PIXEL_BITS-1:0] st_wdata_o,
  output logic                  push_o,
  output logic [EntryBits-1:0]  entry_o
);

  localparam int unsigned WBits = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int unsigned XS    = WBits + 2;
  localparam int unsigned YS    = 18;

  typedef struct packed {
    logic [ColBits-1:0]  col;
    logic [SlotBits-1:0] slot;
    logic [RadBits-1:0]  xr;
    logic [RadBits-1:0]  yr;
    logic                last;
  } entry_t;

  function automatic logic [SlotBits-1:0] slot_inc(input logic [SlotBits-1:0] s);
    return (s == SlotBits'(StoreRows - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [ColBits-1:0]  col_q, col_d;
  logic [15:0]         row_q, row_d;
  logic [SlotBits-1:0] slot_q, slot_d;

  logic [WBits-1:0]    sw, w_eff, col0, col1;
  logic [15:0]         h_eff;
  logic [RadBits-1:0]  xr, yr;
  logic [16:0]         row0, row1;
  logic [SlotBits-1:0] slot0, slot1;
  logic signed [XS-1:0] cx, w_s, xb_s, xr_s;
  logic signed [YS-1:0] cy, h_s, yb_s, yr_s;
  logic                emit, accept;
  entry_t              entry;

  always_comb begin
    sw = WBits'(cfg_i.source_width);
    priority if (sw == '0) begin
      w_eff = WBits'(1);
    end else if (sw > WBits'(MAX_WIDTH)) begin
      w_eff = WBits'(MAX_WIDTH);
    end else begin
      w_eff = sw;
    end
    h_eff = (cfg_i.source_height == '0) ? 16'd1 : cfg_i.source_height;
    xr = RadBits'(cfg_i.x_radius);
    if (xr > RadBits'(MAX_RADIUS)) begin
      xr = RadBits'(MAX_RADIUS);
    end
    yr = RadBits'(cfg_i.y_radius);
    if (yr > RadBits'(MAX_RADIUS)) begin
      yr = RadBits'(MAX_RADIUS);
    end

    // A position left out of range by a configuration change is folded
    // into the next row or a new frame before the pixel is placed.
    col0  = WBits'(col_q);
    row0  = {1'b0, row_q};
    slot0 = slot_q;
    if (col0 >= w_eff) begin
      col0  = '0;
      row0  = row0 + 17'd1;
      slot0 = slot_inc(slot0);
    end
    if (row0 >= {1'b0, h_eff}) begin
      row0  = '0;
      slot0 = '0;
    end

    xr_s = $signed(XS'(xr));
    xb_s = $signed(XS'(cfg_i.x_border));
    w_s  = $signed(XS'(w_eff));
    cx   = $signed(XS'(col0)) - xr_s;
    yr_s = $signed(YS'(yr));
    yb_s = $signed(YS'(cfg_i.y_border));
    h_s  = $signed(YS'(h_eff));
    cy   = $signed(YS'(row0)) - yr_s;

    emit = (xr_s <= xb_s) && (yr_s <= yb_s) &&
           (w_s > (xb_s <<< 1)) && (h_s > (yb_s <<< 1)) &&
           (cx >= xb_s) && (cx < w_s - xb_s) &&
           (cy >= yb_s) && (cy < h_s - yb_s);

    entry.col  = ColBits'(col0);
    entry.slot = slot0;
    entry.xr   = xr;
    entry.yr   = yr;
    entry.last = (cx == w_s - xb_s - $signed(XS'(1))) &&
                 (cy == h_s - yb_s - $signed(YS'(1)));

    col1  = col0 + WBits'(1);
    row1  = row0;
    slot1 = slot0;
    if (col1 >= w_eff) begin
      col1  = '0;
      row1  = row0 + 17'd1;
      slot1 = slot_inc(slot0);
      if (row1 >= {1'b0, h_eff}) begin
        row1  = '0;
        slot1 = '0;
      end
    end
    col_d  = ColBits'(col1);
    row_d  = row1[15:0];
    slot_d = slot1;
  end

  assign pix_ready_o = !hold_i;
  assign accept      = pix_valid_i && !hold_i;
  assign st_we_o     = accept;
  assign st_waddr_o  = AddrBits'(slot0 * MAX_WIDTH) + AddrBits'(col0);
  assign st_wdata_o  = pix_data_i;
  assign push_o      = accept && emit;
  assign entry_o     = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

endmodule

// ===== sv/wmf_fifo.sv =====
// ----------------------------------------------------------------------------
// wmf_fifo: two-entry job queue
// Holds window jobs between the intake and the median engine.
// ----------------------------------------------------------------------------
module wmf_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = data_q[rptr_q];
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/wmf_back.sv =====
// ----------------------------------------------------------------------------
// wmf_back: window gather and median selection
// Copies a job's window from the line store into a window memory, then
// picks the median one bit per pass over the window, MSB first.
// ----------------------------------------------------------------------------
module wmf_back #(
  parameter int unsigned MAX_WIDTH  = wmf_pkg::MaxWidthDef,
  parameter int unsigned MAX_RADIUS = wmf_pkg::MaxRadiusDef,
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef,
  localparam int unsigned StoreRows = 2 * MAX_RADIUS + 1,
  localparam int unsigned SlotBits  = $clog2(StoreRows),
  localparam int unsigned ColBits   = $clog2(MAX_WIDTH),
  localparam int unsigned AddrBits  = $clog2(StoreRows * MAX_WIDTH),
  localparam int unsigned RadBits   = wmf_pkg::RadiusBits,
  localparam int unsigned EntryBits = ColBits + SlotBits + 2 * RadBits + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  signed_i,
  input  logic                  job_valid_i,
  input  logic [EntryBits-1:0]  job_i,
  output logic                  job_pop_o,
  output logic                  gathering_o,
  output logic                  st_re_o,
  output logic [AddrBits-1:0]   st_raddr_o,
  input  logic [PIXEL_BITS-1:0] st_rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] out_median_o,
  output logic                  out_last_o
);

  localparam int unsigned NWin = StoreRows * StoreRows;
  localparam int unsigned NB   = $clog2(NWin + 1);
  localparam int unsigned IB   = (NWin > 1) ? $clog2(NWin) : 1;
  localparam int unsigned BB   = $clog2(PIXEL_BITS);

  typedef struct packed {
    logic [ColBits-1:0]  col;
    logic [SlotBits-1:0] slot;
    logic [RadBits-1:0]  xr;
    logic [RadBits-1:0]  yr;
    logic                last;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_GATHER, S_SELECT, S_DONE} state_e;

  state_e              state_q;
  entry_t              ent_q, job;
  logic [NB-1:0]       n_q, cnt_q, rank_q, cnt_new, n_job;
  logic [SlotBits-1:0] g_slot_q;
  logic [ColBits-1:0]  g_col_q, col_start, col_start_job;
  logic                g_done_q, dv_q;
  logic [IB-1:0]       widx_q, ridx_q;
  logic                issued_q, sv_q, slast_q;
  logic [BB-1:0]       bit_q;
  logic [PIXEL_BITS-1:0] res_q, key, flip, win_rdata_q;
  logic [PIXEL_BITS-1:0] win_mem [NWin];
  logic                out_valid_q, out_last_q;
  logic [PIXEL_BITS-1:0] out_median_q;
  logic [SlotBits:0]   ss;
  logic                issue_g, issue_s, hit;

  assign job = entry_t'(job_i);

  always_comb begin
    ss = (SlotBits + 1)'(job.slot) + (SlotBits + 1)'(StoreRows) -
         (SlotBits + 1)'({job.yr, 1'b0});
    if (ss >= (SlotBits + 1)'(StoreRows)) begin
      ss = ss - (SlotBits + 1)'(StoreRows);
    end
  end

  assign n_job         = NB'({job.xr, 1'b1}) * NB'({job.yr, 1'b1});
  assign col_start_job = job.col - ColBits'({job.xr, 1'b0});
  assign col_start     = ent_q.col - ColBits'({ent_q.xr, 1'b0});

  assign issue_g     = (state_q == S_GATHER) && !g_done_q;
  assign issue_s     = (state_q == S_SELECT) && !issued_q;
  assign st_re_o     = issue_g;
  assign st_raddr_o  = AddrBits'(g_slot_q * MAX_WIDTH) + AddrBits'(g_col_q);
  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign gathering_o = (state_q == S_GATHER);

  assign flip    = signed_i ? {1'b1, {(PIXEL_BITS - 1){1'b0}}} : '0;
  assign key     = win_rdata_q ^ flip;
  assign hit     = ((key >> bit_q) == (res_q >> bit_q));
  assign cnt_new = cnt_q + NB'(hit);

  always_ff @(posedge clk_i) begin
    if (dv_q && (state_q == S_GATHER)) begin
      win_mem[widx_q] <= st_rdata_i;
    end
    if (issue_s) begin
      win_rdata_q <= win_mem[ridx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ent_q        <= '0;
      n_q          <= '0;
      g_slot_q     <= '0;
      g_col_q      <= '0;
      g_done_q     <= 1'b0;
      dv_q         <= 1'b0;
      widx_q       <= '0;
      ridx_q       <= '0;
      issued_q     <= 1'b0;
      sv_q         <= 1'b0;
      slast_q      <= 1'b0;
      cnt_q        <= '0;
      rank_q       <= '0;
      res_q        <= '0;
      bit_q        <= '0;
      out_valid_q  <= 1'b0;
      out_median_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            ent_q    <= job;
            n_q      <= n_job;
            g_slot_q <= SlotBits'(ss);
            g_col_q  <= col_start_job;
            g_done_q <= 1'b0;
            dv_q     <= 1'b0;
            widx_q   <= '0;
            state_q  <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (issue_g) begin
            if ((g_slot_q == ent_q.slot) && (g_col_q == ent_q.col)) begin
              g_done_q <= 1'b1;
            end else if (g_col_q == ent_q.col) begin
              g_col_q  <= col_start;
              g_slot_q <= (g_slot_q == SlotBits'(StoreRows - 1)) ? '0 : g_slot_q + 1'b1;
            end else begin
              g_col_q <= g_col_q + 1'b1;
            end
          end
          dv_q <= issue_g;
          if (dv_q) begin
            widx_q <= widx_q + 1'b1;
            if (widx_q == IB'(n_q - 1'b1)) begin
              bit_q    <= BB'(PIXEL_BITS - 1);
              ridx_q   <= '0;
              issued_q <= 1'b0;
              sv_q     <= 1'b0;
              slast_q  <= 1'b0;
              cnt_q    <= '0;
              rank_q   <= n_q >> 1;
              res_q    <= '0;
              state_q  <= S_SELECT;
            end
          end
        end
        S_SELECT: begin
          if (issue_s) begin
            ridx_q <= ridx_q + 1'b1;
            if (ridx_q == IB'(n_q - 1'b1)) begin
              issued_q <= 1'b1;
            end
          end
          sv_q    <= issue_s;
          slast_q <= issue_s && (ridx_q == IB'(n_q - 1'b1));
          if (sv_q) begin
            cnt_q <= cnt_new;
            if (slast_q) begin
              // End of one pass: fix this bit of the median.
              if (cnt_new <= rank_q) begin
                rank_q <= rank_q - cnt_new;
                res_q  <= res_q | (PIXEL_BITS'(1) << bit_q);
              end
              cnt_q    <= '0;
              ridx_q   <= '0;
              issued_q <= 1'b0;
              if (bit_q == '0) begin
                state_q <= S_DONE;
              end else begin
                bit_q <= bit_q - 1'b1;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_median_q <= res_q ^ flip;
            out_last_q   <= ent_q.last;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_median_o = out_median_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== sv/windowed_median_image_filter.sv =====
// ----------------------------------------------------------------------------
// windowed_median_image_filter: streaming two-dimensional median filter
// Line-buffered median over a configurable window for bordered images.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transfer, and every pixel of the
// interior (the source minus x_border columns and y_border rows on each side)
// yields one result transfer carrying the median of the window centred on it,
// with frame_last set on the final interior pixel. The intake writes each
// accepted pixel into the line store; a pixel that completes a
// window queues a job for the median engine. The engine first copies the
// n = (2*x_radius+1)*(2*y_radius+1) window samples out of the line store, one
// per cycle through its single read port, and then decides the median bit by
// bit, MSB first, with one pass over the window memory per bit. While
// the engine copies a window, and while a job waits in the queue, the intake
// holds off new pixels so the line store cannot be overwritten under it;
// during the bitwise passes pixels flow in freely. A finished result sits in
// an output register, so the engine can start the next job before it is
// taken. Configuration writes are always accepted and must only be made
// while the block is idle. Line store contents are not cleared at reset.
// ----------------------------------------------------------------------------
module windowed_median_image_filter #(
  parameter int unsigned MAX_WIDTH  = wmf_pkg::MaxWidthDef,
  parameter int unsigned MAX_RADIUS = wmf_pkg::MaxRadiusDef,
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  wmf_cfg_if.sink      cfg_i,
  wmf_pixel_if.sink    pix_i,
  wmf_result_if.source res_o
);

  localparam int unsigned StoreRows = 2 * MAX_RADIUS + 1;
  localparam int unsigned SlotBits  = $clog2(StoreRows);
  localparam int unsigned ColBits   = $clog2(MAX_WIDTH);
  localparam int unsigned AddrBits  = $clog2(StoreRows * MAX_WIDTH);
  localparam int unsigned EntryBits = ColBits + SlotBits + 2 * wmf_pkg::RadiusBits + 1;

  // Configuration registers.
  wmf_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wmf_pkg::CfgReset;
    end else if (cfg_i.valid) begin
      unique case (wmf_pkg::cfg_reg_e'(cfg_i.index))
        wmf_pkg::REG_SRC_WIDTH:  cfg_q.source_width  <= cfg_i.data[10:0];
        wmf_pkg::REG_SRC_HEIGHT: cfg_q.source_height <= cfg_i.data[15:0];
        wmf_pkg::REG_X_BORDER:   cfg_q.x_border      <= cfg_i.data[9:0];
        wmf_pkg::REG_Y_BORDER:   cfg_q.y_border      <= cfg_i.data[14:0];
        wmf_pkg::REG_X_RADIUS:   cfg_q.x_radius      <= cfg_i.data[2:0];
        wmf_pkg::REG_Y_RADIUS:   cfg_q.y_radius      <= cfg_i.data[2:0];
        wmf_pkg::REG_SIGNED:     cfg_q.signed_pixels <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Front to back wiring.
  logic                  st_we, st_re;
  logic [AddrBits-1:0]   st_waddr, st_raddr;
  logic [PIXEL_BITS-1:0] st_wdata, st_rdata;
  logic                  push, job_valid, job_pop, gathering, hold;
  logic [EntryBits-1:0]  push_entry, job;

  // The intake waits while a job is pending or its window is being copied.
  assign hold = job_valid || gathering;

  wmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_valid_i(pix_i.valid),
    .pix_data_i (pix_i.pixel),
    .pix_ready_o(pix_i.ready),
    .hold_i     (hold),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  wmf_line_store #(
    .DEPTH    (StoreRows * MAX_WIDTH),
    .ADDR_BITS(AddrBits),
    .DATA_BITS(PIXEL_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  wmf_fifo #(
    .WIDTH(EntryBits)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .valid_o(job_valid),
    .pop_i  (job_pop),
    .data_o (job)
  );

  wmf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .signed_i    (cfg_q.signed_pixels),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .gathering_o (gathering),
    .st_re_o     (st_re),
    .st_raddr_o  (st_raddr),
    .st_rdata_i  (st_rdata),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_median_o(res_o.median),
    .out_last_o  (res_o.frame_last)
  );

endmodule

// ===== sv/wmf_checker.sv =====
// ----------------------------------------------------------------------------
// wmf_checker: port-level checks of the windowed median image filter
// Watches the result and configuration channels over time.
// ----------------------------------------------------------------------------
module wmf_checker #(
  parameter int unsigned PIXEL_BITS = wmf_pkg::PixelBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [PIXEL_BITS-1:0] res_median,
  input logic                  res_last,
  input logic                  cfg_ready
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_median) && $stable(res_last))
    else $error("result changed while stalled");

  // Register writes are never back-pressured.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("configuration channel stalled");

  // No result is offered straight out of reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !res_valid)
    else $error("result offered at reset release");

endmodule

bind windowed_median_image_filter wmf_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_median(res_o.median),
  .res_last  (res_o.frame_last),
  .cfg_ready (cfg_i.ready)
);

// ===== bench/wmf_median_checker.sv =====
// ----------------------------------------------------------------------------
// wmf_median_checker: prediction and comparison for the median filter
// Watches the configuration, pixel and result channels, predicts each window
// median from its own copy of the line store and flags every mismatch.
// ----------------------------------------------------------------------------
module wmf_median_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wmf_cfg_if          cfg,
  wmf_pixel_if        pix,
  wmf_result_if       res,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Rows = 2 * wmf_pkg::MaxRadiusDef + 1;

  typedef struct {
    logic [15:0] median;
    logic        frame_last;
  } median_result_t;

  wmf_pkg::cfg_t  shadow_cfg;
  logic [15:0]    line_copy [Rows * wmf_pkg::MaxWidthDef];
  logic [15:0]    window_keys [Rows * Rows];
  int             column_pos;
  int             row_pos;
  median_result_t expected_medians [$];

  initial begin
    foreach (line_copy[i]) line_copy[i] = '0;
  end

  // Applies one pixel to the shadow state and queues the median it yields.
  task automatic filter_pixel(input logic [15:0] px);
    int             w, h, xr, yr, xb, yb, cx, cy, n, j;
    logic [15:0]    flip, key;
    median_result_t r;
    w    = (shadow_cfg.source_width == 0) ? 1 : int'(shadow_cfg.source_width);
    w    = (w > wmf_pkg::MaxWidthDef) ? wmf_pkg::MaxWidthDef : w;
    h    = (shadow_cfg.source_height == 0) ? 1 : int'(shadow_cfg.source_height);
    xr   = shadow_cfg.x_radius;
    yr   = shadow_cfg.y_radius;
    xb   = shadow_cfg.x_border;
    yb   = shadow_cfg.y_border;
    flip = shadow_cfg.signed_pixels ? 16'h8000 : 16'h0000;
    if (column_pos >= w) begin
      column_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    line_copy[(row_pos % Rows) * wmf_pkg::MaxWidthDef + column_pos] = px;
    cx = column_pos - xr;
    cy = row_pos - yr;
    if (xr <= xb && yr <= yb && w > 2 * xb && h > 2 * yb &&
        cx >= xb && cx < w - xb && cy >= yb && cy < h - yb) begin
      n = 0;
      for (int dy = 2 * yr; dy >= 0; dy--) begin
        for (int dx = 2 * xr; dx >= 0; dx--) begin
          key = line_copy[((row_pos - dy) % Rows) * wmf_pkg::MaxWidthDef +
                          column_pos - dx] ^ flip;
          // Insertion sort on the flipped keys keeps the window ordered.
          j = n;
          while (j > 0 && window_keys[j-1] > key) begin
            window_keys[j] = window_keys[j-1];
            j--;
          end
          window_keys[j] = key;
          n++;
        end
      end
      r.median     = window_keys[n / 2] ^ flip;
      r.frame_last = (cx == w - xb - 1) && (cy == h - yb - 1);
      expected_medians.push_back(r);
    end
    column_pos++;
    if (column_pos >= w) begin
      column_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    median_result_t e;
    if (!rst_ni) begin
      shadow_cfg   <= wmf_pkg::CfgReset;
      column_pos   = 0;
      row_pos      = 0;
      mismatches_o <= 0;
      pending_o    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (wmf_pkg::cfg_reg_e'(cfg.index))
          wmf_pkg::REG_SRC_WIDTH:  shadow_cfg.source_width  <= cfg.data[10:0];
          wmf_pkg::REG_SRC_HEIGHT: shadow_cfg.source_height <= cfg.data[15:0];
          wmf_pkg::REG_X_BORDER:   shadow_cfg.x_border      <= cfg.data[9:0];
          wmf_pkg::REG_Y_BORDER:   shadow_cfg.y_border      <= cfg.data[14:0];
          wmf_pkg::REG_X_RADIUS:   shadow_cfg.x_radius      <= cfg.data[2:0];
          wmf_pkg::REG_Y_RADIUS:   shadow_cfg.y_radius      <= cfg.data[2:0];
          wmf_pkg::REG_SIGNED:     shadow_cfg.signed_pixels <= cfg.data[0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) filter_pixel(pix.pixel);
      if (res.valid && res.ready) begin
        if (expected_medians.size() == 0) begin
          $error("unexpected result transfer: median %h", res.median);
          mismatches_o <= mismatches_o + 1;
        end else begin
          e = expected_medians.pop_front();
          if (res.median !== e.median) begin
            $error("median: expected %h, actual %h", e.median, res.median);
            mismatches_o <= mismatches_o + 1;
          end else if (res.frame_last !== e.frame_last) begin
            $error("frame_last: expected %b, actual %b", e.frame_last, res.frame_last);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      pending_o = expected_medians.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the windowed median image filter
// Programs a series of image geometries and windows, streams pixel frames in
// bursts against a stalling receiver, and lets the checker compare results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_sent = 0;
  int          burst_left = 0;

  wmf_cfg_if    cfg ();
  wmf_pixel_if  pix ();
  wmf_result_if res ();

  windowed_median_image_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .res_o  (res)
  );

  wmf_median_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .pix          (pix),
    .res          (res),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  // The whole run, worst windows and long stalls included, fits well inside
  // this bound; reaching it means the block stopped producing results.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver switches its stall pattern at random between always ready,
  // coin flips and only rare stalls. The long hold-off overrides all three.
  initial begin
    int  mode;
    logic take;
    res.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk_i);
        case (mode)
          0:       take = 1'b1;
          1:       take = $urandom_range(0, 1);
          default: take = ($urandom_range(0, 7) != 0);
        endcase
        res.ready <= take && !hold_off;
      end
    end
  end

  // Once, partway through the oversized-width frame, the receiver stops taking
  // results for a long stretch so that the engine and then the intake back up.
  initial begin
    wait (pixels_sent >= 700);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (1500) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Offers one pixel and returns at the falling edge after its transfer.
  // Bursts of random length are separated by random gaps, often none at all.
  task automatic send_pixel(input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    pix.valid <= 1'b1;
    pix.pixel <= value;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(16'($urandom));
  endtask

  task automatic write_reg(input wmf_pkg::cfg_reg_e index, input logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
  endtask

  // Lets the block drain completely, then rewrites every register. Positions
  // stay frame aligned except where a geometry change is meant to wrap them.
  task automatic set_geometry(input int w, input int h, input int xb, input int yb,
                              input int xr, input int yr, input bit sgn);
    pix.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    write_reg(wmf_pkg::REG_SRC_WIDTH, 16'(w));
    write_reg(wmf_pkg::REG_SRC_HEIGHT, 16'(h));
    write_reg(wmf_pkg::REG_X_BORDER, 16'(xb));
    write_reg(wmf_pkg::REG_Y_BORDER, 16'(yb));
    write_reg(wmf_pkg::REG_X_RADIUS, 16'(xr));
    write_reg(wmf_pkg::REG_Y_RADIUS, 16'(yr));
    write_reg(wmf_pkg::REG_SIGNED, 16'(sgn));
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] corner_values [10] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
      16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA};
    int w, h, xb, yb, xr, yr, frames;

    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Signed 3x3 median over a 5x5 frame built from extreme pixel codes.
    set_geometry(5, 5, 1, 1, 1, 1, 1'b1);
    for (int i = 0; i < 25; i++) begin
      send_pixel(i < 10 ? corner_values[i] : corner_values[(i * 7) % 10]);
    end
    // A horizontal radius wider than its border suppresses every result.
    set_geometry(3, 3, 0, 1, 1, 1, 1'b0);
    send_random_pixels(9);
    // Borders that consume the whole width leave an empty interior.
    set_geometry(2, 3, 1, 0, 0, 0, 1'b0);
    send_random_pixels(6);
    // Every field but x_border at its top code: the clamped width still has no interior.
    set_geometry(2047, 65535, 512, 32767, 7, 7, 1'b1);
    send_random_pixels(8);
    // Zero width and height count as one, so each pixel is its own frame and
    // the leftover position of the previous geometry wraps to a fresh frame.
    set_geometry(0, 0, 0, 0, 0, 0, 1'b0);
    send_random_pixels(4);
    // The largest window, 15x15, around the single interior pixel.
    set_geometry(15, 15, 7, 7, 7, 7, 1'b0);
    send_random_pixels(225);
    // An oversized width is clamped, which moves the interior to 510..513.
    set_geometry(1500, 1, 510, 0, 0, 0, 1'b1);
    send_random_pixels(520);
    set_geometry(0, 0, 0, 0, 0, 0, 1'b1);
    send_random_pixels(3);

    // Random geometries with whole frames of random content. Windows stay
    // mostly inside their borders so that results keep coming.
    while (pixels_sent < 1350) begin
      w  = $urandom_range(1, 12);
      h  = $urandom_range(1, 12);
      xb = $urandom_range(0, (w - 1) / 2);
      yb = $urandom_range(0, (h - 1) / 2);
      xb = (xb > 3) ? 3 : xb;
      yb = (yb > 3) ? 3 : yb;
      if ($urandom_range(0, 9) == 0) begin
        xr = $urandom_range(0, 7);
        yr = $urandom_range(0, 7);
      end else begin
        xr = $urandom_range(0, (xb > 2) ? 2 : xb);
        yr = $urandom_range(0, (yb > 2) ? 2 : yb);
      end
      set_geometry(w, h, xb, yb, xr, yr, 1'($urandom_range(0, 1)));
      frames = 40 / (w * h);
      frames = (frames < 1) ? 1 : frames;
      send_random_pixels(frames * w * h);
    end

    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== windowed_median_image_filter.f =====
sv/wmf_pkg.sv
sv/wmf_if.sv
sv/wmf_line_store.sv
sv/wmf_front.sv
sv/wmf_fifo.sv
sv/wmf_back.sv
sv/windowed_median_image_filter.sv
sv/wmf_checker.sv
bench/wmf_median_checker.sv
bench/tb_top.sv
